### rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// Prefix subscription table package
// Shared constants, item types, codes and sequencer states.
// ----------------------------------------------------------------------------
package pst_pkg;

   localparam int ENTRIES_DEF   = 64;
   localparam int NAME_BITS_DEF = 128;
   localparam int NAME_MAX      = 128;
   localparam int LEN_W         = 8;
   localparam int SUB_W         = 64;
   localparam int HALF_W        = 64;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_REMOVE,
      OP_LOOKUP,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE,
      ST_DUP,
      ST_FULL,
      ST_NOTFOUND,
      ST_MATCH
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [HALF_W-1:0]  name_high;
      logic [HALF_W-1:0]  name_low;
      logic [LEN_W-1:0]   prefix_len;
      logic [SUB_W-1:0]   subscriber;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [SUB_W-1:0]   match_subscriber;
      logic [LEN_W-1:0]   match_len;
      logic               last;
   } rsp_type;

endpackage

### rtl/pst_cell.sv
// ----------------------------------------------------------------------------
// Prefix subscription table cell
// One table entry; takes its neighbour's entry on every shift.
// ----------------------------------------------------------------------------
module pst_cell import pst_pkg::*; #(
   parameter int NAME_BITS = NAME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  logic                 in_valid,
   input  logic [NAME_BITS-1:0] in_prefix,
   input  logic [LEN_W-1:0]     in_len,
   input  logic [SUB_W-1:0]     in_sub,
   output logic                 out_valid,
   output logic [NAME_BITS-1:0] out_prefix,
   output logic [LEN_W-1:0]     out_len,
   output logic [SUB_W-1:0]     out_sub
);

   logic                 valid_ff;
   logic [NAME_BITS-1:0] prefix_ff;
   logic [LEN_W-1:0]     len_ff;
   logic [SUB_W-1:0]     sub_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         prefix_ff <= in_prefix;
         len_ff    <= in_len;
         sub_ff    <= in_sub;
      end
   end

   assign out_valid  = valid_ff;
   assign out_prefix = prefix_ff;
   assign out_len    = len_ff;
   assign out_sub    = sub_ff;

endmodule

### rtl/pst_ctrl.sv
// ----------------------------------------------------------------------------
// Prefix subscription table sequencer
// Rotates the cell chain once per item and works on the entry at its head.
// ----------------------------------------------------------------------------
module pst_ctrl import pst_pkg::*; #(
   parameter int ENTRIES   = ENTRIES_DEF,
   parameter int NAME_BITS = NAME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_valid,
   output rsp_type              rsp_item,
   input  logic                 head_valid,
   input  logic [NAME_BITS-1:0] head_prefix,
   input  logic [LEN_W-1:0]     head_len,
   input  logic [SUB_W-1:0]     head_sub,
   input  logic                 next_valid,
   input  logic [NAME_BITS-1:0] next_prefix,
   input  logic [LEN_W-1:0]     next_len,
   input  logic [SUB_W-1:0]     next_sub,
   input  logic                 last_valid,
   output logic                 shift,
   output logic                 tail_valid,
   output logic [NAME_BITS-1:0] tail_prefix,
   output logic [LEN_W-1:0]     tail_len,
   output logic [SUB_W-1:0]     tail_sub
);

   localparam int                CW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [CW-1:0]     LAST_IDX = CW'(ENTRIES - 1);
   localparam logic [LEN_W-1:0]  NB_LEN   = LEN_W'(NAME_BITS);

   function automatic logic [NAME_BITS-1:0] len_mask(input logic [LEN_W-1:0] l);
      len_mask = ~({NAME_BITS{1'b1}} >> l);
   endfunction

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   op_type               op_ff, op_in;
   logic [NAME_BITS-1:0] key_prefix_ff, key_prefix_in;
   logic [LEN_W-1:0]     key_len_ff, key_len_in;
   logic [SUB_W-1:0]     key_sub_ff, key_sub_in;
   logic                 full_ff, full_in;
   logic                 dup_ff, dup_in;
   logic                 gone_ff, gone_in;
   logic                 carry_valid_ff, carry_valid_in;
   logic [NAME_BITS-1:0] carry_prefix_ff, carry_prefix_in;
   logic [LEN_W-1:0]     carry_len_ff, carry_len_in;
   logic [SUB_W-1:0]     carry_sub_ff, carry_sub_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [LEN_W-1:0]     pend_len_ff, pend_len_in;
   logic [SUB_W-1:0]     pend_sub_ff, pend_sub_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                   accept;
   logic [NAME_MAX-1:0]    name_full;
   logic [NAME_BITS-1:0]   name_nb;
   logic [LEN_W-1:0]       len_sat;
   logic [NAME_BITS-1:0]   req_mask;
   logic                   triple;
   logic                   hit;
   logic                   carry_less;

   assign accept    = start && (state_ff == S_IDLE);
   assign name_full = {req_item.name_high, req_item.name_low};
   assign name_nb   = name_full[NAME_MAX-1 -: NAME_BITS];
   assign len_sat   = (req_item.prefix_len > NB_LEN) ? NB_LEN : req_item.prefix_len;
   assign req_mask  = (req_item.op == OP_ADD || req_item.op == OP_REMOVE) ?
                      len_mask(len_sat) : {NAME_BITS{1'b1}};

   assign triple = head_valid && (head_prefix == key_prefix_ff) &&
                   (head_len == key_len_ff) && (head_sub == key_sub_ff);
   assign hit    = head_valid &&
                   (((head_prefix ^ key_prefix_ff) & len_mask(head_len)) == '0);
   assign carry_less = carry_valid_ff &&
                       (!head_valid || ({carry_len_ff, carry_sub_ff} < {head_len, head_sub}));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (count_ff == LAST_IDX) state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in        = count_ff;
      op_in           = op_ff;
      key_prefix_in   = key_prefix_ff;
      key_len_in      = key_len_ff;
      key_sub_in      = key_sub_ff;
      full_in         = full_ff;
      dup_in          = dup_ff;
      gone_in         = gone_ff;
      carry_valid_in  = carry_valid_ff;
      carry_prefix_in = carry_prefix_ff;
      carry_len_in    = carry_len_ff;
      carry_sub_in    = carry_sub_ff;
      pend_valid_in   = pend_valid_ff;
      pend_len_in     = pend_len_ff;
      pend_sub_in     = pend_sub_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = '0;
      shift           = 1'b0;
      tail_valid      = head_valid;
      tail_prefix     = head_prefix;
      tail_len        = head_len;
      tail_sub        = head_sub;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               count_in        = '0;
               op_in           = req_item.op;
               key_prefix_in   = name_nb & req_mask;
               key_len_in      = len_sat;
               key_sub_in      = req_item.subscriber;
               full_in         = last_valid;
               dup_in          = 1'b0;
               gone_in         = 1'b0;
               carry_valid_in  = (req_item.op == OP_ADD) && !last_valid;
               carry_prefix_in = name_nb & req_mask;
               carry_len_in    = len_sat;
               carry_sub_in    = req_item.subscriber;
               pend_valid_in   = 1'b0;
            end
         end
         S_SCAN: begin
            shift    = 1'b1;
            count_in = count_ff + CW'(1);
            case (op_ff)
               OP_ADD: begin
                  if (triple) begin
                     dup_in         = 1'b1;
                     carry_valid_in = 1'b0;
                  end else if (carry_less) begin
                     tail_valid      = 1'b1;
                     tail_prefix     = carry_prefix_ff;
                     tail_len        = carry_len_ff;
                     tail_sub        = carry_sub_ff;
                     carry_valid_in  = head_valid;
                     carry_prefix_in = head_prefix;
                     carry_len_in    = head_len;
                     carry_sub_in    = head_sub;
                  end
               end
               OP_REMOVE: begin
                  if (gone_ff || triple) begin
                     gone_in     = 1'b1;
                     tail_valid  = (count_ff == LAST_IDX) ? 1'b0 : next_valid;
                     tail_prefix = next_prefix;
                     tail_len    = next_len;
                     tail_sub    = next_sub;
                  end
               end
               OP_LOOKUP: begin
                  if (hit) begin
                     if (pend_valid_ff) begin
                        rsp_valid_in            = 1'b1;
                        rsp_in.status           = ST_MATCH;
                        rsp_in.match_subscriber = pend_sub_ff;
                        rsp_in.match_len        = pend_len_ff;
                        rsp_in.last             = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_len_in   = head_len;
                     pend_sub_in   = head_sub;
                  end
               end
               default: begin
               end
            endcase
         end
         S_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_in.last   = 1'b1;
            rsp_in.status = ST_NOTFOUND;
            case (op_ff)
               OP_ADD: begin
                  if (dup_ff)       rsp_in.status = ST_DUP;
                  else if (full_ff) rsp_in.status = ST_FULL;
                  else              rsp_in.status = ST_DONE;
               end
               OP_REMOVE: begin
                  if (gone_ff) rsp_in.status = ST_DONE;
               end
               OP_LOOKUP: begin
                  if (pend_valid_ff) begin
                     rsp_in.status           = ST_MATCH;
                     rsp_in.match_subscriber = pend_sub_ff;
                     rsp_in.match_len        = pend_len_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff        <= count_in;
      op_ff           <= op_in;
      key_prefix_ff   <= key_prefix_in;
      key_len_ff      <= key_len_in;
      key_sub_ff      <= key_sub_in;
      full_ff         <= full_in;
      dup_ff          <= dup_in;
      gone_ff         <= gone_in;
      carry_valid_ff  <= carry_valid_in;
      carry_prefix_ff <= carry_prefix_in;
      carry_len_ff    <= carry_len_in;
      carry_sub_ff    <= carry_sub_in;
      pend_valid_ff   <= pend_valid_in;
      pend_len_ff     <= pend_len_in;
      pend_sub_ff     <= pend_sub_in;
      rsp_ff          <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### rtl/prefix_subscription_table_unit.sv
// ----------------------------------------------------------------------------
// Prefix subscription table
// Each item passes through the scan and finish states: busy rises
// after acceptance, the entry chain rotates once through the single compare
// unit at its head, one entry a cycle, and the finish state issues the final
// result. Entries are kept ordered by length, then subscriber, so lookup
// matches stream out during the rotation; rsp_valid is a one-cycle strobe and
// the receiver must take every result as it comes, as it cannot stall.
// ----------------------------------------------------------------------------
module prefix_subscription_table_unit import pst_pkg::*; #(
   parameter int ENTRIES   = ENTRIES_DEF,
   parameter int NAME_BITS = NAME_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   logic                 cell_valid  [ENTRIES];
   logic [NAME_BITS-1:0] cell_prefix [ENTRIES];
   logic [LEN_W-1:0]     cell_len    [ENTRIES];
   logic [SUB_W-1:0]     cell_sub    [ENTRIES];

   logic                 shift;
   logic                 tail_valid;
   logic [NAME_BITS-1:0] tail_prefix;
   logic [LEN_W-1:0]     tail_len;
   logic [SUB_W-1:0]     tail_sub;
   logic                 next_valid;
   logic [NAME_BITS-1:0] next_prefix;
   logic [LEN_W-1:0]     next_len;
   logic [SUB_W-1:0]     next_sub;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == ENTRIES - 1) begin : g_tail
         pst_cell #(.NAME_BITS(NAME_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift      (shift),
            .in_valid   (tail_valid),
            .in_prefix  (tail_prefix),
            .in_len     (tail_len),
            .in_sub     (tail_sub),
            .out_valid  (cell_valid[i]),
            .out_prefix (cell_prefix[i]),
            .out_len    (cell_len[i]),
            .out_sub    (cell_sub[i])
         );
      end else begin : g_body
         pst_cell #(.NAME_BITS(NAME_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift      (shift),
            .in_valid   (cell_valid[i+1]),
            .in_prefix  (cell_prefix[i+1]),
            .in_len     (cell_len[i+1]),
            .in_sub     (cell_sub[i+1]),
            .out_valid  (cell_valid[i]),
            .out_prefix (cell_prefix[i]),
            .out_len    (cell_len[i]),
            .out_sub    (cell_sub[i])
         );
      end
   end

   if (ENTRIES > 1) begin : g_next
      assign next_valid  = cell_valid[1];
      assign next_prefix = cell_prefix[1];
      assign next_len    = cell_len[1];
      assign next_sub    = cell_sub[1];
   end else begin : g_no_next
      assign next_valid  = 1'b0;
      assign next_prefix = '0;
      assign next_len    = '0;
      assign next_sub    = '0;
   end

   pst_ctrl #(
      .ENTRIES   (ENTRIES),
      .NAME_BITS (NAME_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .head_valid  (cell_valid[0]),
      .head_prefix (cell_prefix[0]),
      .head_len    (cell_len[0]),
      .head_sub    (cell_sub[0]),
      .next_valid  (next_valid),
      .next_prefix (next_prefix),
      .next_len    (next_len),
      .next_sub    (next_sub),
      .last_valid  (cell_valid[ENTRIES-1]),
      .shift       (shift),
      .tail_valid  (tail_valid),
      .tail_prefix (tail_prefix),
      .tail_len    (tail_len),
      .tail_sub    (tail_sub)
   );

endmodule

### rtl/pst_checker.sv
// ----------------------------------------------------------------------------
// Prefix subscription table checker
// Port-level checks on item acceptance and result sequencing.
// ----------------------------------------------------------------------------
module pst_checker import pst_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_nonmatch_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_MATCH |->
         rsp_item.last && rsp_item.match_subscriber == '0 && rsp_item.match_len == '0)
      else $error("non-match result not final or carries match fields");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last |-> !busy)
      else $error("final result while still busy");

   a_end_final: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid && rsp_item.last)
      else $error("item ended without a final result");

endmodule

bind prefix_subscription_table_unit pst_checker u_pst_checker (.*);
